// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its condition.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/icrt_pkg.sv
`default_nettype none

package icrt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int REF_BITS      = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [CNT_W-1:0]    ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [REF_BITS-1:0] REF_LIMIT   = {REF_BITS{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_LOAD      = 3'd1,
    ST_FULL      = 3'd2,
    ST_HELD      = 3'd3,
    ST_CLEAN     = 3'd4,
    ST_WRITEBACK = 3'd5,
    ST_UNDERFLOW = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]          device;
    logic [31:0]         inode;
    logic [REF_BITS-1:0] refs;
    logic                modified;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } tbl_req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_index;
    logic [31:0] disk_block;
    logic [2:0]  block_offset;
    logic [7:0]  ref_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/icrt_table.sv
`default_nettype none

module icrt_table import icrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tbl_req_t req,
  output entry_t        rd_data
);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  entry_t                   rd_q;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // An entry never written reads as the cleared value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/icrt_seq.sv
`default_nettype none

module icrt_seq import icrt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  device,
  input  wire logic [31:0] inode_number,
  input  wire logic [5:0]  slot,
  input  wire logic        mark_dirty,
  input  wire logic [31:0] table_start,
  input  wire logic        out_free,
  output logic             res_fire,
  output result_t          res,
  output tbl_req_t         req,
  input  wire entry_t      rd_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_PUT    = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t              state;
  logic [7:0]          key_dev;
  logic [31:0]         key_ino;
  logic [31:0]         ino_m1;
  logic [IDX_W-1:0]    put_slot;
  logic                put_dirty;
  logic [CNT_W-1:0]    iss;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;
  entry_t              hit_ent;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  status_t             res_status;
  logic [5:0]          res_slot;
  logic [REF_BITS-1:0] res_refs;
  logic                res_blk;

  logic                slot_ok;
  logic                match;
  logic [REF_BITS-1:0] put_refs;
  logic                put_mod;

  assign slot_ok  = int'(slot) < TABLE_ENTRIES;
  assign match    = (rd_data.device == key_dev) && (rd_data.inode == key_ino);
  assign put_refs = rd_data.refs - REF_BITS'(1);
  assign put_mod  = rd_data.modified | put_dirty;
  assign in_stall = (state != S_IDLE);
  assign res_fire = (state == S_RESP) && out_free;

  always_comb begin
    req         = '0;
    req.rd_addr = (state == S_SCAN) ? iss[IDX_W-1:0] : IDX_W'(slot);
    unique case (state)
      S_IDLE: begin
        req.rd_en = in_valid && (op == OP_PUT) && slot_ok;
      end
      S_SCAN: begin
        req.rd_en = (iss != ENTRIES_CNT);
      end
      S_DECIDE: begin
        if (hit_found) begin
          req.wr_en        = (hit_ent.refs != REF_LIMIT);
          req.wr_addr      = hit_idx;
          req.wr_data      = hit_ent;
          req.wr_data.refs = hit_ent.refs + REF_BITS'(1);
        end else begin
          req.wr_en   = free_found;
          req.wr_addr = free_idx;
          req.wr_data = '{device: key_dev, inode: key_ino, refs: REF_BITS'(1),
                          modified: 1'b0};
        end
      end
      S_PUT: begin
        req.wr_en            = (rd_data.refs != '0);
        req.wr_addr          = put_slot;
        req.wr_data          = rd_data;
        req.wr_data.refs     = put_refs;
        req.wr_data.modified = (put_refs != '0) ? put_mod : 1'b0;
      end
      S_RESP: begin
        req.rd_en = 1'b0;
      end
      default: begin
        req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_dev    <= device;
            key_ino    <= inode_number;
            ino_m1     <= inode_number - 32'd1;
            put_slot   <= IDX_W'(slot);
            put_dirty  <= mark_dirty;
            iss        <= '0;
            cmp_valid  <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (op == OP_GET) begin
              state <= S_SCAN;
            end else if (slot_ok) begin
              state <= S_PUT;
            end else begin
              res_status <= ST_UNDERFLOW;
              res_slot   <= slot;
              res_refs   <= '0;
              res_blk    <= 1'b0;
              state      <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (iss != ENTRIES_CNT) begin
            iss <= iss + CNT_W'(1);
          end
          cmp_valid <= (iss != ENTRIES_CNT);
          cmp_idx   <= iss[IDX_W-1:0];
          if (cmp_valid) begin
            if (!hit_found && match) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_ent   <= rd_data;
            end
            if (!free_found && (rd_data.refs == '0)) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
          if (!cmp_valid && (iss == ENTRIES_CNT)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_blk <= 1'b0;
          if (hit_found) begin
            res_slot <= 6'(hit_idx);
            if (hit_ent.refs == REF_LIMIT) begin
              res_status <= ST_OVERFLOW;
              res_refs   <= hit_ent.refs;
            end else begin
              res_status <= ST_HIT;
              res_refs   <= hit_ent.refs + REF_BITS'(1);
            end
          end else if (free_found) begin
            res_status <= ST_LOAD;
            res_slot   <= 6'(free_idx);
            res_refs   <= REF_BITS'(1);
            res_blk    <= 1'b1;
          end else begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            res_refs   <= '0;
          end
          state <= S_RESP;
        end
        S_PUT: begin
          res_slot <= 6'(put_slot);
          res_blk  <= 1'b0;
          if (rd_data.refs == '0) begin
            res_status <= ST_UNDERFLOW;
            res_refs   <= '0;
          end else if (put_refs != '0) begin
            res_status <= ST_HELD;
            res_refs   <= put_refs;
          end else if (put_mod) begin
            res_status <= ST_WRITEBACK;
            res_refs   <= '0;
            res_blk    <= 1'b1;
            ino_m1     <= rd_data.inode - 32'd1;
          end else begin
            res_status <= ST_CLEAN;
            res_refs   <= '0;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Block address of the inode: table start plus eight inodes to a block.
  always_comb begin
    res.status       = res_status;
    res.slot_index   = res_slot;
    res.disk_block   = res_blk ? (table_start + {3'b000, ino_m1[31:3]}) : 32'd0;
    res.block_offset = res_blk ? ino_m1[2:0] : 3'd0;
    res.ref_count    = 8'(res_refs);
  end

endmodule

`default_nettype wire

// File: hw/rtl/inode_cache_refcount_table.sv
// Channel  Direction  Handshake          Word
// in       in         in_valid/in_stall  op, device, inode_number, slot, mark_dirty
// out      out        out_valid/out_stall status, slot_index, disk_block, block_offset,
//                                        ref_count
// cfg      in         cfg_wr_en          cfg_wr_data (inode table start)
//
// A get scans all 64 table entries through one read port, one entry per cycle,
// then updates the hit or free entry that it found and forms the result word.
// A put reads its one entry and rewrites it unless its count is already zero.
// One word is in work at a time; in_stall is high from acceptance until the
// result word has moved into the output register, which holds it under out_stall.
// Reset makes every table entry read as zero at once and clears the start register.
`default_nettype none

module inode_cache_refcount_table import icrt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  device,
  input  wire logic [31:0] inode_number,
  input  wire logic [5:0]  slot,
  input  wire logic        mark_dirty,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [5:0]       slot_index,
  output logic [31:0]      disk_block,
  output logic [2:0]       block_offset,
  output logic [7:0]       ref_count
);

  logic [31:0] table_start;
  logic        out_free;
  logic        res_fire;
  result_t     res;
  tbl_req_t    req;
  entry_t      rd_data;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_start <= '0;
    end else if (cfg_wr_en) begin
      table_start <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      status       <= res.status;
      slot_index   <= res.slot_index;
      disk_block   <= res.disk_block;
      block_offset <= res.block_offset;
      ref_count    <= res.ref_count;
    end
  end

  icrt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  icrt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .device       (device),
    .inode_number (inode_number),
    .slot         (slot),
    .mark_dirty   (mark_dirty),
    .table_start  (table_start),
    .out_free     (out_free),
    .res_fire     (res_fire),
    .res          (res),
    .req          (req),
    .rd_data      (rd_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/icrt_checker.sv
`default_nettype none

`include "assert_macros.svh"

module icrt_checker import icrt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [5:0]  slot_index,
  input wire logic [31:0] disk_block,
  input wire logic [2:0]  block_offset,
  input wire logic [7:0]  ref_count
);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "block took a word without going busy")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(disk_block), "stalled result word changed")
  `ASSERT_IMPL(a_full_empty, clk, rst, out_valid && (status == ST_FULL), (slot_index == 6'd0) && (ref_count == 8'd0), "full result carries a slot or count")
  `ASSERT_IMPL(a_load_count, clk, rst, out_valid && (status == ST_LOAD), ref_count == 8'd1, "newly claimed entry count is not one")
  `ASSERT_IMPL(a_no_block, clk, rst, out_valid && (status != ST_LOAD) && (status != ST_WRITEBACK), (disk_block == 32'd0) && (block_offset == 3'd0), "block address on a result without disk access")

endmodule

bind inode_cache_refcount_table icrt_checker u_icrt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .slot_index   (slot_index),
  .disk_block   (disk_block),
  .block_offset (block_offset),
  .ref_count    (ref_count)
);

`default_nettype wire

// File: tb/tb_inode_cache_refcount_table.sv
`timescale 1ns / 1ps

module tb_inode_cache_refcount_table;
  import icrt_pkg::*;

  localparam int POOL_SIZE = 12;

  typedef struct {
    logic        op;
    logic [7:0]  device;
    logic [31:0] inode_number;
    logic [5:0]  slot;
    logic        mark_dirty;
  } inode_req_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_GET;
  logic [7:0]  device = '0;
  logic [31:0] inode_number = '0;
  logic [5:0]  slot = '0;
  logic        mark_dirty = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [31:0] disk_block;
  logic [2:0]  block_offset;
  logic [7:0]  ref_count;

  logic [7:0]          cache_dev   [TABLE_ENTRIES];
  logic [31:0]         cache_ino   [TABLE_ENTRIES];
  logic [REF_BITS-1:0] cache_refs  [TABLE_ENTRIES];
  logic                cache_dirty [TABLE_ENTRIES];
  logic [31:0]         table_start;

  logic [7:0]  pool_dev [POOL_SIZE];
  logic [31:0] pool_ino [POOL_SIZE];

  inode_req_t inode_requests[$];
  result_t    result_words_due[$];
  inode_req_t on_port;
  int         words_queued = 0;
  int         words_accepted = 0;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  inode_cache_refcount_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .device       (device),
    .inode_number (inode_number),
    .slot         (slot),
    .mark_dirty   (mark_dirty),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot_index   (slot_index),
    .disk_block   (disk_block),
    .block_offset (block_offset),
    .ref_count    (ref_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns the disk block and the offset within it of an inode.
  function automatic logic [34:0] locate_inode(input logic [31:0] ino);
    logic [31:0] ino_less;
    ino_less = ino - 32'd1;
    return {table_start + (ino_less >> 3), ino_less[2:0]};
  endfunction

  function automatic result_t apply_inode_op(input inode_req_t r);
    result_t res;
    int      hit;
    int      free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    if (r.op == OP_GET) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && cache_dev[i] == r.device && cache_ino[i] == r.inode_number) hit = i;
        if (free_slot < 0 && cache_refs[i] == '0) free_slot = i;
      end
      if (hit >= 0) begin
        res.slot_index = 6'(hit);
        if (cache_refs[hit] == REF_LIMIT) begin
          res.status = ST_OVERFLOW;
        end else begin
          cache_refs[hit] = cache_refs[hit] + REF_BITS'(1);
          res.status = ST_HIT;
        end
        res.ref_count = cache_refs[hit];
      end else if (free_slot >= 0) begin
        cache_refs[free_slot] = REF_BITS'(1);
        cache_dev[free_slot] = r.device;
        cache_ino[free_slot] = r.inode_number;
        cache_dirty[free_slot] = 1'b0;
        res.status = ST_LOAD;
        res.slot_index = 6'(free_slot);
        {res.disk_block, res.block_offset} = locate_inode(r.inode_number);
        res.ref_count = 8'd1;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      res.slot_index = r.slot;
      if (cache_refs[r.slot] == '0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        cache_dirty[r.slot] = cache_dirty[r.slot] | r.mark_dirty;
        cache_refs[r.slot] = cache_refs[r.slot] - REF_BITS'(1);
        res.ref_count = cache_refs[r.slot];
        if (cache_refs[r.slot] != '0) begin
          res.status = ST_HELD;
        end else if (cache_dirty[r.slot]) begin
          cache_dirty[r.slot] = 1'b0;
          res.status = ST_WRITEBACK;
          {res.disk_block, res.block_offset} = locate_inode(cache_ino[r.slot]);
        end else begin
          res.status = ST_CLEAN;
        end
      end
    end
    return res;
  endfunction

  // Fields that an operation ignores still carry random values.
  task automatic push_get(input logic [7:0] dev, input logic [31:0] ino);
    inode_req_t r;
    r.op = OP_GET;
    r.device = dev;
    r.inode_number = ino;
    r.slot = 6'($urandom());
    r.mark_dirty = 1'($urandom());
    inode_requests.push_back(r);
    words_queued++;
  endtask

  task automatic push_put(input logic [5:0] s, input logic dirty);
    inode_req_t r;
    r.op = OP_PUT;
    r.device = 8'($urandom());
    r.inode_number = $urandom();
    r.slot = s;
    r.mark_dirty = dirty;
    inode_requests.push_back(r);
    words_queued++;
  endtask

  // Mostly gets and puts on a small working set, so that hits, held and
  // released entries come up often; the rest is random noise.
  task automatic queue_mixed(input int count);
    int pick;
    int k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = $urandom_range(POOL_SIZE - 1);
      if (pick < 45) push_get(pool_dev[k], pool_ino[k]);
      else if (pick < 80) push_put(6'($urandom_range(15)), 1'($urandom()));
      else if (pick < 90) push_get(8'($urandom()), $urandom());
      else push_put(6'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic write_table_start(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    table_start = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_until_idle();
    while (words_accepted != words_queued || result_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_words_due.push_back(apply_inode_op(on_port));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (inode_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = inode_requests.pop_front();
          in_valid <= 1'b1;
          op <= on_port.op;
          device <= on_port.device;
          inode_number <= on_port.inode_number;
          slot <= on_port.slot;
          mark_dirty <= on_port.mark_dirty;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(status);
        got.slot_index = slot_index;
        got.disk_block = disk_block;
        got.block_offset = block_offset;
        got.ref_count = ref_count;
        if (result_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: status %0d slot %0d block %h offset %0d refs %0d",
                     got.status, got.slot_index, got.disk_block, got.block_offset,
                     got.ref_count);
        end else begin
          want = result_words_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch: expected status %0d slot %0d block %h offset %0d refs %0d",
                       want.status, want.slot_index, want.disk_block, want.block_offset,
                       want.ref_count);
              $display("               got status %0d slot %0d block %h offset %0d refs %0d",
                       got.status, got.slot_index, got.disk_block, got.block_offset,
                       got.ref_count);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    logic [7:0]  run_dev;
    logic [31:0] run_ino;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cache_dev[i] = '0;
      cache_ino[i] = '0;
      cache_refs[i] = '0;
      cache_dirty[i] = 1'b0;
    end
    table_start = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_dev[k] = 8'($urandom());
      pool_ino[k] = $urandom();
    end
    pool_dev[0] = 8'h00;
    pool_ino[0] = 32'h0;
    pool_ino[1] = 32'hFFFF_FFFF;
    pool_ino[2] = 32'h1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 10;
    recv_idle_pct = 84;
    write_table_start(32'h0);
    // The reset contents hold device 0 inode 0, so the first get is a hit.
    push_get(8'h00, 32'h0);
    push_put(6'd0, 1'b1);
    push_put(6'd0, 1'b0);
    push_get(8'hFF, 32'hFFFF_FFFF);
    push_get(8'hFF, 32'hFFFF_FFFF);
    push_get(8'h00, 32'h1);
    push_put(6'd1, 1'b0);
    push_get(8'h00, 32'h1);
    push_put(6'd0, 1'b1);
    push_put(6'd0, 1'b0);
    push_get(8'h5A, 32'h8);
    push_get(8'h5A, 32'h9);
    push_put(6'd63, 1'b1);
    push_get(8'h01, 32'h0);
    push_get(8'hA5, 32'h8000_0000);
    push_put(6'd2, 1'b1);
    push_put(6'd3, 1'b1);
    queue_mixed(20);
    wait_until_idle();

    send_idle_pct = 84;
    recv_idle_pct = 10;
    write_table_start(32'hFFFF_FFFF);
    queue_mixed(20);
    // Claim every free entry and then some, then put every slot once.
    for (int n = 0; n < 70; n++) push_get(8'($urandom()), $urandom());
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      push_put(6'(s), 1'($urandom()));
    end
    wait_until_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_table_start($urandom());
    queue_mixed(20);
    // Drive one entry up to the count limit and past it.
    run_dev = 8'hC3;
    run_ino = $urandom();
    for (int n = 0; n < 258; n++) push_get(run_dev, run_ino);
    wait_until_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && result_words_due.size() == 0) begin
      $display("tb_inode_cache_refcount_table passed");
    end else begin
      $display("tb_inode_cache_refcount_table failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_inode_cache_refcount_table failed");
    $finish;
  end

endmodule

// File: inode_cache_refcount_table.f
+incdir+hw/rtl
hw/rtl/icrt_pkg.sv
hw/rtl/icrt_table.sv
hw/rtl/icrt_seq.sv
hw/rtl/inode_cache_refcount_table.sv
hw/rtl/icrt_checker.sv
tb/tb_inode_cache_refcount_table.sv
